>>> hdl/eppb_pkg.sv
package eppb_pkg;

    localparam logic [7:0] SYNC_BYTE       = 8'hAA;
    localparam logic [7:0] MAX_LEN         = 8'd170;
    localparam logic [7:0] EXCODE_BYTE     = 8'h55;
    localparam logic [7:0] CODE_QUALITY    = 8'h02;
    localparam logic [7:0] CODE_ATTENTION  = 8'h04;
    localparam logic [7:0] CODE_MEDITATION = 8'h05;
    localparam logic [7:0] CODE_EXTENDED   = 8'h80;
    localparam logic [7:0] QUALITY_DEFAULT = 8'd200;
    localparam logic [7:0] BAR_MAX_LEVEL   = 8'd100;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CSUM  = 2'd1;
    localparam logic [1:0] ST_LEN   = 2'd2;

    // bit positions in the seen flags
    localparam int FLAG_ATT  = 0;
    localparam int FLAG_MED  = 1;
    localparam int FLAG_QUAL = 2;

    localparam int OUT_BITS  = 40;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] attention;
        logic [7:0] meditation;
        logic [7:0] quality;
        logic [2:0] flags;
        logic [7:0] bar_level;
    } evt_t;

    // thermometer pattern for a level of at most 100
    function automatic logic [7:0] bar_for_level(input logic [7:0] lv);
        logic [7:0] pat;
        if (lv <= 8'd20)      pat = 8'h01;
        else if (lv <= 8'd30) pat = 8'h03;
        else if (lv <= 8'd40) pat = 8'h07;
        else if (lv <= 8'd50) pat = 8'h0F;
        else if (lv <= 8'd60) pat = 8'h1F;
        else if (lv <= 8'd70) pat = 8'h3F;
        else if (lv <= 8'd80) pat = 8'h7F;
        else                  pat = 8'hFF;
        return pat;
    endfunction

endpackage

>>> hdl/eeg_packet_parser_bargraph_unit.sv
// EEG sensor packet parser with LED bargraph.
//
// s_tdata carries one received serial byte per word. The front end hunts two
// 0xAA sync bytes, reads the length, checksums the payload and decodes the
// quality, attention and meditation rows. At the checksum byte, or at a length
// byte above 170, it pushes one packet event into a small queue.
// The back end turns each event into one m_ word and keeps the bar register.
// m_tdata, from bit 0 up: packet_status[1:0], attention_level[9:2],
// meditation_level[17:10], signal_quality[25:18], bar_pattern[33:26],
// attention_seen[34], meditation_seen[35], quality_seen[36], zeros[39:37].
// Throughput: one byte per cycle while s_tready is high. m_tvalid rises once the
// event of the checksum or bad length byte has passed the queue and output register.
// When m_tready is held low the queue fills (EVT_DEPTH events plus the output
// register) and then s_tready drops until a word is taken.
// Reset (aresetn low, synchronous) returns to sync hunting, clears the queue,
// the output valid flag and the bar register.
module eeg_packet_parser_bargraph_unit
    import eppb_pkg::*;
#(
    parameter int EVT_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // rx_byte[7:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata    // see field list above
);

    evt_t       push_evt, pop_evt;
    logic       push, pop, full, empty;
    logic [1:0] status;
    logic [7:0] att, med, qual, bar;
    logic [2:0] flags;

    eppb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .byte_data  (s_tdata),
        .evt_full   (full),
        .evt_push   (push),
        .evt_data   (push_evt)
    );

    eppb_fifo #(
        .DEPTH (EVT_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_evt),
        .pop       (pop),
        .pop_data  (pop_evt),
        .full      (full),
        .empty     (empty)
    );

    eppb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .evt_empty      (empty),
        .evt_data       (pop_evt),
        .evt_pop        (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (status),
        .out_attention  (att),
        .out_meditation (med),
        .out_quality    (qual),
        .out_bar        (bar),
        .out_flags      (flags)
    );

    assign m_tdata = {3'b000, flags[FLAG_QUAL], flags[FLAG_MED], flags[FLAG_ATT],
                      bar, qual, med, att, status};

endmodule

>>> hdl/eppb_front.sv
module eppb_front
    import eppb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] byte_data,
    input  logic       evt_full,
    output logic       evt_push,
    output evt_t       evt_data
);

    localparam logic [2:0] FP_SYNC1   = 3'd0;
    localparam logic [2:0] FP_SYNC2   = 3'd1;
    localparam logic [2:0] FP_LEN     = 3'd2;
    localparam logic [2:0] FP_PAYLOAD = 3'd3;
    localparam logic [2:0] FP_CHECK   = 3'd4;

    localparam logic [1:0] RP_CODE  = 2'd0;
    localparam logic [1:0] RP_VALUE = 2'd1;
    localparam logic [1:0] RP_XLEN  = 2'd2;
    localparam logic [1:0] RP_SKIP  = 2'd3;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] sum_reg, sum_next;
    logic [1:0] rphase_reg, rphase_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] skip_reg, skip_next;
    logic [7:0] att_reg, att_next;
    logic [7:0] med_reg, med_next;
    logic [7:0] qual_reg, qual_next;
    logic [2:0] flags_reg, flags_next;
    logic [7:0] lvl_reg, lvl_next;
    logic       acc;

    assign byte_ready = !evt_full;
    assign acc = byte_valid && byte_ready;

    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        sum_next    = sum_reg;
        rphase_next = rphase_reg;
        code_next   = code_reg;
        skip_next   = skip_reg;
        att_next    = att_reg;
        med_next    = med_reg;
        qual_next   = qual_reg;
        flags_next  = flags_reg;
        lvl_next    = lvl_reg;
        evt_push    = 1'b0;
        evt_data.status     = ST_OK;
        evt_data.attention  = att_reg;
        evt_data.meditation = med_reg;
        evt_data.quality    = qual_reg;
        evt_data.flags      = flags_reg;
        evt_data.bar_level  = lvl_reg;
        if (acc) begin
            unique case (phase_reg)
                FP_SYNC2: begin
                    phase_next = (byte_data == SYNC_BYTE) ? FP_LEN : FP_SYNC1;
                end
                FP_LEN: begin
                    if (byte_data == SYNC_BYTE) begin
                        phase_next = FP_LEN;
                    end else if (byte_data > MAX_LEN) begin
                        phase_next      = FP_SYNC1;
                        evt_push        = 1'b1;
                        evt_data.status = ST_LEN;
                    end else begin
                        left_next   = byte_data;
                        sum_next    = '0;
                        rphase_next = RP_CODE;
                        code_next   = '0;
                        skip_next   = '0;
                        att_next    = '0;
                        med_next    = '0;
                        qual_next   = QUALITY_DEFAULT;
                        flags_next  = '0;
                        lvl_next    = '0;
                        phase_next  = (byte_data == 8'd0) ? FP_CHECK : FP_PAYLOAD;
                    end
                end
                FP_PAYLOAD: begin
                    sum_next  = sum_reg + byte_data;
                    left_next = left_reg - 8'd1;
                    if (left_next == 8'd0) begin
                        phase_next = FP_CHECK;
                    end
                    unique case (rphase_reg)
                        RP_VALUE: begin
                            if (code_reg == CODE_QUALITY) begin
                                qual_next            = byte_data;
                                flags_next[FLAG_QUAL] = 1'b1;
                            end else if (code_reg == CODE_ATTENTION) begin
                                att_next             = byte_data;
                                lvl_next             = byte_data;
                                flags_next[FLAG_ATT] = 1'b1;
                            end else if (code_reg == CODE_MEDITATION) begin
                                med_next             = byte_data;
                                lvl_next             = byte_data;
                                flags_next[FLAG_MED] = 1'b1;
                            end
                            rphase_next = RP_CODE;
                        end
                        RP_XLEN: begin
                            skip_next   = byte_data;
                            rphase_next = (byte_data == 8'd0) ? RP_CODE : RP_SKIP;
                        end
                        RP_SKIP: begin
                            skip_next = skip_reg - 8'd1;
                            if (skip_next == 8'd0) begin
                                rphase_next = RP_CODE;
                            end
                        end
                        default: begin
                            code_next = byte_data;
                            if (byte_data == EXCODE_BYTE) begin
                                rphase_next = RP_CODE;
                            end else if (byte_data >= CODE_EXTENDED) begin
                                rphase_next = RP_XLEN;
                            end else begin
                                rphase_next = RP_VALUE;
                            end
                        end
                    endcase
                end
                FP_CHECK: begin
                    phase_next      = FP_SYNC1;
                    evt_push        = 1'b1;
                    evt_data.status = (byte_data != ~sum_reg) ? ST_CSUM : ST_OK;
                end
                default: begin
                    phase_next = (byte_data == SYNC_BYTE) ? FP_SYNC2 : FP_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= FP_SYNC1;
            left_reg   <= '0;
            sum_reg    <= '0;
            rphase_reg <= RP_CODE;
            code_reg   <= '0;
            skip_reg   <= '0;
            att_reg    <= '0;
            med_reg    <= '0;
            qual_reg   <= QUALITY_DEFAULT;
            flags_reg  <= '0;
            lvl_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            sum_reg    <= sum_next;
            rphase_reg <= rphase_next;
            code_reg   <= code_next;
            skip_reg   <= skip_next;
            att_reg    <= att_next;
            med_reg    <= med_next;
            qual_reg   <= qual_next;
            flags_reg  <= flags_next;
            lvl_reg    <= lvl_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_check_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && phase_reg == FP_CHECK) |=> (phase_reg == FP_SYNC1))
        else $error("frame did not restart after checksum word");

    a_push_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        evt_push |-> (acc && (phase_reg == FP_CHECK || phase_reg == FP_LEN)))
        else $error("event pushed outside checksum or length word");

    a_payload_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == FP_PAYLOAD) |-> (left_reg != 8'd0))
        else $error("payload phase with no bytes left");
`endif

endmodule

>>> hdl/eppb_fifo.sv
module eppb_fifo
    import eppb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  evt_t push_data,
    input  logic pop,
    output evt_t pop_data,
    output logic full,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    evt_t          mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          do_push, do_pop;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count above depth");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("word pushed into full queue");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + (AW+1)'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

>>> hdl/eppb_back.sv
module eppb_back
    import eppb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       evt_empty,
    input  evt_t       evt_data,
    output logic       evt_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_status,
    output logic [7:0] out_attention,
    output logic [7:0] out_meditation,
    output logic [7:0] out_quality,
    output logic [7:0] out_bar,
    output logic [2:0] out_flags
);

    logic       valid_reg;
    logic [7:0] bar_reg, bar_next;
    logic [1:0] status_reg;
    logic [7:0] att_reg, med_reg, qual_reg;
    logic [2:0] flags_reg;
    logic       good;

    assign evt_pop = !evt_empty && (!valid_reg || out_ready);
    assign good    = (evt_data.status == ST_OK);

    always_comb begin
        bar_next = bar_reg;
        if (good && (evt_data.flags[FLAG_ATT] || evt_data.flags[FLAG_MED])
            && evt_data.bar_level <= BAR_MAX_LEVEL) begin
            bar_next = bar_for_level(evt_data.bar_level);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            bar_reg   <= '0;
        end else begin
            if (evt_pop) begin
                valid_reg <= 1'b1;
                bar_reg   <= bar_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // error words show zeros and the unchanged bar
    always_ff @(posedge aclk) begin
        if (evt_pop) begin
            status_reg <= evt_data.status;
            att_reg    <= good ? evt_data.attention  : 8'd0;
            med_reg    <= good ? evt_data.meditation : 8'd0;
            qual_reg   <= good ? evt_data.quality    : 8'd0;
            flags_reg  <= good ? evt_data.flags      : 3'd0;
        end
    end

    assign out_valid      = valid_reg;
    assign out_status     = status_reg;
    assign out_attention  = att_reg;
    assign out_meditation = med_reg;
    assign out_quality    = qual_reg;
    assign out_bar        = bar_reg;
    assign out_flags      = flags_reg;

`ifndef NO_ASSERTIONS
    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg != ST_OK) |->
            (att_reg == 8'd0 && med_reg == 8'd0 && qual_reg == 8'd0 && flags_reg == 3'd0))
        else $error("error word carries level fields");

    a_bar_only_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(evt_pop) |-> $stable(bar_reg))
        else $error("bar changed without a word");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (status_reg == ST_OK || status_reg == ST_CSUM || status_reg == ST_LEN))
        else $error("bad status on output");
`endif

endmodule
